@@ sv/lbwr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwr_pkg
// Shared constants, payload types and control structs for the line bit word
// repacker.
// ----------------------------------------------------------------------------
package lbwr_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_LINE_BITS = 2048;
  localparam int BYTE_BITS     = 8;
  localparam int BYTE_SHIFT    = $clog2(BYTE_BITS);

  localparam int STORE_BYTES = (MAX_LINE_BITS + BYTE_BITS - 1) / BYTE_BITS;
  localparam int POS_W       = $clog2(STORE_BYTES);
  localparam int ADDR_W      = POS_W + 1;

  localparam int LEN_W      = 12;
  localparam int MAX_WORDS  = (MAX_LINE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = $clog2(MAX_WORDS);
  localparam int NWORDS_W   = $clog2(MAX_WORDS + 1);
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int WIN_BYTES  = WORD_BITS / BYTE_BITS + 1;
  localparam int WIN_BITS   = WIN_BYTES * BYTE_BITS;
  localparam int FETCH_W    = $clog2(WIN_BYTES + 1);
  localparam int BIT_W      = WIDX_W + OFF_W + 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [1:0] REG_PAD_FRONT   = 2'd1;
  localparam logic [1:0] REG_REVERSE     = 2'd2;

  localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = LEN_W'(32);

  typedef struct packed {
    logic [BYTE_BITS-1:0] source_byte;
    logic                 final_line;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic                 line_done;
    logic                 stream_done;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [BYTE_BITS-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [NWORDS_W-1:0] nwords;
    logic [OFF_W-1:0]    offset;
    logic                reverse;
    logic                final_line;
    logic                bank;
  } job_t;

  typedef struct packed {
    logic [LEN_W-1:0] line_length_bits;
    logic             pad_at_front;
    logic             reverse_words;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EMIT
  } back_state_t;

endpackage

@@ sv/lbwr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwr_store
// Two-bank line byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbwr_store (
  input  logic                    clk,
  input  lbwr_pkg::mem_wr_t       wr,
  input  logic [lbwr_pkg::ADDR_W-1:0]    raddr,
  output logic [lbwr_pkg::BYTE_BITS-1:0] rdata
);
  import lbwr_pkg::*;

  logic [BYTE_BITS-1:0] mem [2*STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lbwr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwr_queue
// Two-entry job queue between the byte front end and the word back end.
// ----------------------------------------------------------------------------
module lbwr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lbwr_pkg::job_t push_job,
  input  logic           pop,
  output logic           job_valid,
  output lbwr_pkg::job_t head,
  output logic           full
);
  import lbwr_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head      = entries[rd_ptr];
  assign job_valid = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ sv/lbwr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwr_front
// Accepts source bytes, stores them and queues a job when a line completes.
// ----------------------------------------------------------------------------
module lbwr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lbwr_pkg::item_t   item,
  input  lbwr_pkg::cfg_t    cfg,
  output lbwr_pkg::mem_wr_t wr,
  output logic              push,
  output lbwr_pkg::job_t    push_job
);
  import lbwr_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic             bank;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] neg_len;
  logic [LEN_W:0]   len_bytes_up;
  logic [LEN_W:0]   len_words_up;
  logic [POS_W:0]   nbytes;
  logic [POS_W:0]   pos_plus;
  logic             line_end;

  // Out-of-range lengths are clamped to 1 .. MAX_LINE_BITS.
  always_comb begin
    if (cfg.line_length_bits == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.line_length_bits > LEN_W'(MAX_LINE_BITS)) begin
      eff_len = LEN_W'(MAX_LINE_BITS);
    end else begin
      eff_len = cfg.line_length_bits;
    end
  end

  assign len_bytes_up = {1'b0, eff_len} + (LEN_W+1)'(BYTE_BITS - 1);
  assign len_words_up = {1'b0, eff_len} + (LEN_W+1)'(WORD_BITS - 1);
  assign nbytes       = (POS_W+1)'(len_bytes_up >> BYTE_SHIFT);
  assign neg_len      = -eff_len;
  assign pos_plus     = {1'b0, byte_position} + (POS_W+1)'(1);
  assign line_end     = (pos_plus >= nbytes);

  assign wr.en   = accept;
  assign wr.addr = {bank, byte_position};
  assign wr.data = item.source_byte;

  assign push = accept && line_end;

  always_comb begin
    push_job.len        = eff_len;
    push_job.nwords     = NWORDS_W'(len_words_up >> OFF_W);
    push_job.offset     = cfg.pad_at_front ? neg_len[OFF_W-1:0] : '0;
    push_job.reverse    = cfg.reverse_words;
    push_job.final_line = item.final_line;
    push_job.bank       = bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      bank          <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        byte_position <= '0;
        bank          <= ~bank;
      end else begin
        byte_position <= pos_plus[POS_W-1:0];
      end
    end
  end

endmodule

@@ sv/lbwr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwr_back
// Reads a completed line from the store and emits it as padded words.
// ----------------------------------------------------------------------------
module lbwr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  lbwr_pkg::job_t                 head,
  output logic                           pop,
  output logic [lbwr_pkg::ADDR_W-1:0]    raddr,
  input  logic [lbwr_pkg::BYTE_BITS-1:0] rdata,
  output logic                           strobe,
  output lbwr_pkg::result_t              result
);
  import lbwr_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  logic [WIDX_W-1:0]   k;
  logic [FETCH_W-1:0]  fc;
  logic [WIN_BITS-1:0] window;
  logic                rd_ok_q;

  logic [WIDX_W-1:0]          last_k;
  logic [WIDX_W-1:0]          u;
  logic signed [BIT_W-1:0]    s0;
  logic signed [BIT_W-1:0]    byte_base;
  logic signed [BIT_W-1:0]    idx;
  logic                       rd_ok;
  logic                       last_word;
  logic                       fetch_done;
  logic                       emit;
  logic [WIN_BITS-1:0]        shifted;
  logic [WORD_BITS-1:0]       word_masked;

  assign last_k    = WIDX_W'(head.nwords - NWORDS_W'(1));
  assign u         = head.reverse ? (last_k - k) : k;
  assign last_word = (k == last_k);

  // First source bit of logical word u; negative where front padding lies.
  assign s0 = $signed({{(BIT_W-WIDX_W-OFF_W){1'b0}}, u, {OFF_W{1'b0}}})
            - $signed({{(BIT_W-OFF_W){1'b0}}, head.offset});
  assign byte_base = s0 >>> BYTE_SHIFT;
  assign idx       = byte_base + $signed({{(BIT_W-FETCH_W){1'b0}}, fc});
  assign rd_ok     = !idx[BIT_W-1] && (idx < $signed(BIT_W'(STORE_BYTES)));
  assign raddr     = {head.bank, idx[POS_W-1:0]};

  assign fetch_done = (fc == FETCH_W'(WIN_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = B_FETCH;
        end
      end
      B_FETCH: begin
        if (fetch_done) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        emit = 1'b1;
        if (last_word) begin
          pop        = 1'b1;
          state_next = B_IDLE;
        end else begin
          state_next = B_FETCH;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Align the five-byte window to the word and zero bits outside the line.
  always_comb begin
    logic signed [BIT_W-1:0] bit_pos;
    shifted     = window >> s0[BYTE_SHIFT-1:0];
    word_masked = shifted[WORD_BITS-1:0];
    for (int b = 0; b < WORD_BITS; b++) begin
      bit_pos = s0 + $signed(BIT_W'(b));
      if (bit_pos[BIT_W-1] || (bit_pos >= $signed({{(BIT_W-LEN_W){1'b0}}, head.len}))) begin
        word_masked[b] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        k  <= '0;
        fc <= '0;
      end
      B_FETCH: begin
        fc      <= fc + FETCH_W'(1);
        rd_ok_q <= rd_ok;
        if (fc != '0) begin
          window <= {(rd_ok_q ? rdata : {BYTE_BITS{1'b0}}), window[WIN_BITS-1:BYTE_BITS]};
        end
      end
      B_EMIT: begin
        fc                 <= '0;
        k                  <= k + WIDX_W'(1);
        result.packed_word <= word_masked;
        result.line_done   <= last_word;
        result.stream_done <= last_word && head.final_line;
      end
      default: begin
        fc <= '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

endmodule

@@ sv/line_bit_word_repacker_core.sv @@
`timescale 1ns / 1ps
// Order: the line's job is queued when its last byte is taken; the back end leaves idle,
// fetches each word window from the store and emits it, and the strobe is registered.
// Throughput: a byte is taken every cycle while fewer than two lines are pending; the
// word back end makes five store reads per word window. Results cannot be stalled.
// Reset: synchronous, clears line position, job queue and sequencer; the line store
// is not cleared, and configuration returns to 32 bits, padding after, forward order.
// ----------------------------------------------------------------------------
// line_bit_word_repacker_core
// Repacks byte-padded configuration lines into zero-padded 32-bit words.
// ----------------------------------------------------------------------------
module line_bit_word_repacker_core (
  input  logic                             clk,
  input  logic                             rst,
  // Command channel: a beat is taken when start is high and busy is low.
  input  logic                             start,
  output logic                             busy,
  input  lbwr_pkg::item_t                  item,
  // Result channel: one beat per strobe cycle, never held off.
  output logic                             strobe,
  output lbwr_pkg::result_t                result,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lbwr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lbwr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lbwr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import lbwr_pkg::*;

  cfg_t              cfg;
  logic              cfg_write;
  logic [1:0]        reg_index;

  logic              accept;
  mem_wr_t           wr;
  logic              push;
  job_t              push_job;
  logic              pop;
  logic              job_valid;
  job_t              head;
  logic              full;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_BITS-1:0] rdata;

  // The register file. Writes complete on the access phase of the bus
  // transfer; there are no wait states, so pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_length_bits <= LINE_LENGTH_RESET;
      cfg.pad_at_front     <= 1'b0;
      cfg.reverse_words    <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_LINE_LENGTH: cfg.line_length_bits <= pwdata[LEN_W-1:0];
        REG_PAD_FRONT:   cfg.pad_at_front     <= pwdata[0];
        REG_REVERSE:     cfg.reverse_words    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_LINE_LENGTH: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg.line_length_bits};
      REG_PAD_FRONT:   prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.pad_at_front};
      REG_REVERSE:     prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.reverse_words};
      default:         prdata = '0;
    endcase
  end

  // The store has two banks, so the front end can fill the next line while
  // the back end is still emitting the previous one. Busy rises only when
  // both banks hold lines that have not yet been fully emitted.
  assign busy   = full;
  assign accept = start && !busy;

  lbwr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg      (cfg),
    .wr       (wr),
    .push     (push),
    .push_job (push_job)
  );

  // Each job keeps its configuration snapshot and bank, and leaves the queue
  // only after its last word has gone out, which frees the bank.
  lbwr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .job_valid (job_valid),
    .head      (head),
    .full      (full)
  );

  lbwr_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  lbwr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .head      (head),
    .pop       (pop),
    .raddr     (raddr),
    .rdata     (rdata),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

@@ sv/lbwr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwr_checker
// Port-level checks on the repacker's command and result behaviour.
// ----------------------------------------------------------------------------
module lbwr_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              strobe,
  input lbwr_pkg::result_t result
);
  import lbwr_pkg::*;

  // The end of a stream is always the end of a line.
  a_stream_ends_line: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.stream_done) |-> result.line_done)
    else $error("stream_done without line_done");

  // Every word needs several store reads, so beats never come back to back.
  a_strobe_spaced: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result beats in consecutive cycles");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy after reset");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result beat after reset");

endmodule

bind line_bit_word_repacker_core lbwr_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
